FILE: hw/rtl/rsk_pkg.sv
// Shared types and constants for the running smallest-K tracker.
package rsk_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned RANK_W   = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } item_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

endpackage

FILE: hw/rtl/running_smallest_k_tracker.sv
// Top level of the running smallest-K tracker: input queue and insert/emit back end.
// A sample accepted into the queue is inserted into the kept list when the back end
// loads it, and its results are then offered from the registered list.
// Throughput: one result per cycle on the output port while out_ready_i is high; each
// sample gives n results, n being the kept count after it (1 to KEEP_COUNT); the back end
// loads the next queued sample on the cycle its previous run ends. Reset empties the queue
// and the kept count; the kept values themselves are not reset.
module running_smallest_k_tracker #(
  parameter int unsigned KEEP_COUNT = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [rsk_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rsk_pkg::SAMPLE_W-1:0] kept_value_o,
  output logic [rsk_pkg::RANK_W-1:0]         rank_o,
  output logic                               last_o
);
  import rsk_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign in_item.sample  = sample_i;
  assign in_item.restart = restart_i;

  rsk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  rsk_back #(
    .KEEP_COUNT (KEEP_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kept_value_o (kept_value_o),
    .rank_o       (rank_o),
    .last_o       (last_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("Run ended before its last value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (rank_o == RANK_W'($past(rank_o) + RANK_W'(1))))
    else $error("Rank did not advance by one within a run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (!out_valid_o || rank_o == '0))
    else $error("New run did not start at rank zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (kept_value_o <= $past(kept_value_o)))
    else $error("Kept values are not in descending order.");

endmodule

FILE: hw/rtl/rsk_front.sv
// Input front end: takes transfers and holds them in a two-entry queue.
module rsk_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsk_pkg::item_t in_item_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output rsk_pkg::item_t q_item_o
);
  import rsk_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push;
  logic        pop;

  assign in_ready_o = (fill_q != 2'd2);
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: hw/rtl/rsk_back.sv
// Back end: inserts each sample into the sorted kept list and emits the list.
module rsk_back #(
  parameter int unsigned KEEP_COUNT = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_pop_o,
  input  rsk_pkg::item_t                     q_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rsk_pkg::SAMPLE_W-1:0] kept_value_o,
  output logic [rsk_pkg::RANK_W-1:0]         rank_o,
  output logic                               last_o
);
  import rsk_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEEP_COUNT + 1);
  localparam int unsigned IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

  logic signed [SAMPLE_W-1:0] kept_q [KEEP_COUNT];
  logic signed [SAMPLE_W-1:0] kept_d [KEEP_COUNT];
  logic [KEEP_COUNT-1:0]      le;
  logic [CNT_W-1:0]           cnt_q, cnt_d, cnt_eff, cnt_new;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [RANK_W-1:0]          rank_q, rank_d;
  back_state_e                state_q, state_d;
  logic                       load;
  logic                       beat;
  logic                       run_end;

  assign beat    = (state_q == BK_EMIT) && out_ready_i;
  assign run_end = beat && (idx_q == '0);
  assign load    = q_valid_i && ((state_q == BK_IDLE) || run_end);
  assign q_pop_o = load;

  // Entries at or below the sample stay; the sample lands after the last of them.
  always_comb begin
    cnt_eff = q_item_i.restart ? '0 : cnt_q;
    for (int unsigned i = 0; i < KEEP_COUNT; i++) begin
      le[i] = (CNT_W'(i) < cnt_eff) && !(kept_q[i] > q_item_i.sample);
    end
    kept_d[0] = le[0] ? kept_q[0] : q_item_i.sample;
    for (int unsigned i = 1; i < KEEP_COUNT; i++) begin
      if (le[i]) begin
        kept_d[i] = kept_q[i];
      end else if (le[i-1]) begin
        kept_d[i] = q_item_i.sample;
      end else begin
        kept_d[i] = kept_q[i-1];
      end
    end
    cnt_new = (cnt_eff == CNT_W'(KEEP_COUNT)) ? cnt_eff : cnt_eff + CNT_W'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (load) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (run_end) begin
          state_d = load ? BK_EMIT : BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    rank_d = rank_q;
    if (load) begin
      cnt_d  = cnt_new;
      idx_d  = IDX_W'(cnt_new - CNT_W'(1));
      rank_d = '0;
    end else if (beat) begin
      idx_d  = idx_q - IDX_W'(1);
      rank_d = rank_q + RANK_W'(1);
    end
  end

  always_comb begin
    out_valid_o  = (state_q == BK_EMIT);
    kept_value_o = kept_q[idx_q];
    rank_o       = rank_q;
    last_o       = (idx_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kept_q <= kept_d;
    end
  end

endmodule
